// ----- design/wta_pkg.sv -----
package wta_pkg;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_TRAIN    = 2'd1,
		OP_CLASSIFY = 2'd2,
		OP_EPOCH    = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_MUL   = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_DECAY   = 1'b1;

	localparam logic [15:0] RATE_RESET  = 16'd6554;
	localparam logic [15:0] DECAY_RESET = 16'd62259;

	localparam int COORD_W = 16;
	localparam int SLOT_W  = 3;
	localparam int DIST_W  = 36;
	// Sum of two squares of 17-bit differences.
	localparam int SUM_W   = 33;

endpackage

// ----- design/winner_take_all_prototype_update_top.sv -----
// Nearest-prototype search and winner update over a prototype memory.
// Throughput: one item at a time; a new transfer is taken only back in the idle state,
// after the previous operation has handed its result to the output register.
// The scan reads one prototype a cycle and finds the winner through a two-stage pipeline.
// Reset (asynchronous, active low) clears the entry valid bits, so every prototype reads
// as zero, and loads the rate registers with their reset values.
module winner_take_all_prototype_update_top #(
	parameter int PROTOTYPES = 7
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [wta_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [15:0]                          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           op,
	input  logic signed [wta_pkg::COORD_W-1:0]   sample_x,
	input  logic signed [wta_pkg::COORD_W-1:0]   sample_y,
	input  logic [wta_pkg::SLOT_W-1:0]           slot,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [wta_pkg::SLOT_W-1:0]           winner_index,
	output logic [wta_pkg::DIST_W-1:0]           winner_distance_sq
);

	localparam int AW = (PROTOTYPES > 1) ? $clog2(PROTOTYPES) : 1;
	localparam int CW = $clog2(PROTOTYPES + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(PROTOTYPES - 1);
	localparam logic [CW-1:0] NUM_PROTO = CW'(PROTOTYPES);

	wta_pkg::state_t state_q;
	wta_pkg::op_t    op_q;

	logic [15:0] decay_q, rate_q;
	logic signed [15:0] sx_q, sy_q;

	// Prototype memory: {x, y} per entry, registered read.
	logic [31:0] mem [PROTOTYPES];
	logic [PROTOTYPES-1:0] vld_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;

	logic [CW-1:0] cnt_q;
	logic          issue;

	logic          v_s1, rd_vld_s1;
	logic [AW-1:0] idx_s1;
	logic [31:0]   rd_data_s1;

	logic          v_s2;
	logic [AW-1:0] idx_s2;
	logic [31:0]   dx2_s2, dy2_s2;
	logic signed [15:0] px_s2, py_s2;

	logic [AW-1:0] best_idx_q;
	logic [wta_pkg::SUM_W-1:0] best_dist_q;
	logic signed [15:0] best_x_q, best_y_q;

	logic signed [33:0] prodx_q, prody_q;

	logic [wta_pkg::SLOT_W-1:0] win_idx_q;
	logic [wta_pkg::DIST_W-1:0] win_dist_q;
	logic out_valid_q;

	logic in_xfer, out_free, load_ok, last_cmp;
	logic signed [15:0] rd_x, rd_y;
	logic signed [16:0] dx_s1, dy_s1, ux, uy;
	logic signed [33:0] sqx, sqy;
	logic [wta_pkg::SUM_W-1:0] sum_s2;
	logic signed [16:0] rate_s;

	assign in_ready  = (state_q == wta_pkg::ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign load_ok   = (32'(slot) < 32'(PROTOTYPES));
	assign issue     = (state_q == wta_pkg::ST_SCAN) && (cnt_q < NUM_PROTO);
	assign last_cmp  = v_s2 && (idx_s2 == LAST_IDX);

	assign out_valid          = out_valid_q;
	assign winner_index       = win_idx_q;
	assign winner_distance_sq = win_dist_q;

	// Entries never written read as zero.
	assign rd_x  = rd_vld_s1 ? $signed(rd_data_s1[31:16]) : 16'sd0;
	assign rd_y  = rd_vld_s1 ? $signed(rd_data_s1[15:0])  : 16'sd0;
	assign dx_s1 = {sx_q[15], sx_q} - {rd_x[15], rd_x};
	assign dy_s1 = {sy_q[15], sy_q} - {rd_y[15], rd_y};
	assign sqx   = dx_s1 * dx_s1;
	assign sqy   = dy_s1 * dy_s1;
	assign sum_s2 = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	assign rate_s = $signed({1'b0, rate_q});
	assign ux     = {sx_q[15], sx_q} - {best_x_q[15], best_x_q};
	assign uy     = {sy_q[15], sy_q} - {best_y_q[15], best_y_q};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = best_idx_q;
		mem_wdata = {16'(best_x_q + prodx_q[31:16]), 16'(best_y_q + prody_q[31:16])};
		if (in_xfer && (wta_pkg::op_t'(op) == wta_pkg::OP_LOAD) && load_ok) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(slot);
			mem_wdata = {sample_x, sample_y};
		end else if (state_q == wta_pkg::ST_WRITE) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[cnt_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[mem_waddr] <= 1'b1;
			end
			rd_vld_s1 <= vld_q[cnt_q[AW-1:0]];
		end
	end

	// Scan pipeline: s1 holds the read data, s2 the two squares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
		idx_s2 <= idx_s1;
		dx2_s2 <= sqx[31:0];
		dy2_s2 <= sqy[31:0];
		px_s2  <= rd_x;
		py_s2  <= rd_y;
		prodx_q <= rate_s * ux;
		prody_q <= rate_s * uy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wta_pkg::ST_IDLE;
			op_q        <= wta_pkg::OP_LOAD;
			cnt_q       <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			best_idx_q  <= '0;
			best_dist_q <= '0;
			best_x_q    <= '0;
			best_y_q    <= '0;
			out_valid_q <= 1'b0;
			win_idx_q   <= '0;
			win_dist_q  <= '0;
			decay_q     <= wta_pkg::DECAY_RESET;
			rate_q      <= wta_pkg::RATE_RESET;
		end else begin
			// In the finishing state the result register is handled below.
			if (out_valid_q && out_ready && (state_q != wta_pkg::ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// Lowest index wins ties: only a strictly smaller distance replaces the best.
			if (v_s2 && ((idx_s2 == '0) || (sum_s2 < best_dist_q))) begin
				best_idx_q  <= idx_s2;
				best_dist_q <= sum_s2;
				best_x_q    <= px_s2;
				best_y_q    <= py_s2;
			end

			case (state_q)
				wta_pkg::ST_IDLE: begin
					if (in_xfer) begin
						op_q        <= wta_pkg::op_t'(op);
						sx_q        <= sample_x;
						sy_q        <= sample_y;
						cnt_q       <= '0;
						best_idx_q  <= '0;
						best_dist_q <= '0;
						case (wta_pkg::op_t'(op))
							wta_pkg::OP_TRAIN, wta_pkg::OP_CLASSIFY: begin
								state_q <= wta_pkg::ST_SCAN;
							end
							wta_pkg::OP_EPOCH: begin
								rate_q  <= 16'((32'(rate_q) * 32'(decay_q)) >> 16);
								state_q <= wta_pkg::ST_FIN;
							end
							default: begin
								state_q <= wta_pkg::ST_FIN;
							end
						endcase
					end
				end
				wta_pkg::ST_SCAN: begin
					if (last_cmp) begin
						state_q <= (op_q == wta_pkg::OP_TRAIN) ? wta_pkg::ST_MUL
							: wta_pkg::ST_FIN;
					end
				end
				wta_pkg::ST_MUL: begin
					state_q <= wta_pkg::ST_WRITE;
				end
				wta_pkg::ST_WRITE: begin
					state_q <= wta_pkg::ST_FIN;
				end
				wta_pkg::ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						win_idx_q   <= wta_pkg::SLOT_W'(best_idx_q);
						win_dist_q  <= wta_pkg::DIST_W'(best_dist_q);
						state_q     <= wta_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= wta_pkg::ST_IDLE;
				end
			endcase

			if (cfg_we) begin
				case (cfg_index)
					wta_pkg::REG_INITIAL_RATE: begin
						rate_q <= cfg_data;
					end
					wta_pkg::REG_RATE_DECAY: begin
						decay_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// A result only leaves the finishing state.
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == wta_pkg::ST_FIN))
		else $error("result raised outside the finishing state");

	// The winner is written back only for a training transfer.
	a_write_train: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wta_pkg::ST_WRITE) |-> (op_q == wta_pkg::OP_TRAIN))
		else $error("prototype write-back for an operation other than train");

	// Compare results only arrive while the scan is running.
	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == wta_pkg::ST_SCAN))
		else $error("scan pipeline active outside the scan");

	// The winning index always names a real prototype.
	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wta_pkg::ST_FIN) |-> (best_idx_q <= LAST_IDX))
		else $error("winner index beyond the prototype table");

	// The scan never issues more reads than there are prototypes.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NUM_PROTO)
		else $error("scan counter overran the prototype table");

endmodule
